// ----- design/quad_motor_mixer_with_arming_top_defines.svh -----
// Assertion macros shared by the motor mixer modules.
`ifndef QUAD_MOTOR_MIXER_WITH_ARMING_TOP_DEFINES_SVH
`define QUAD_MOTOR_MIXER_WITH_ARMING_TOP_DEFINES_SVH

// Property checked on every rising clock edge outside of reset.
`define QMM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold outside of reset.
`define QMM_ASSERT_NEVER(lbl, cond, msg) \
  `QMM_ASSERT(lbl, !(cond), msg)

`endif

// ----- design/qmm_pkg.sv -----
// Package with the types, codes and constants of the quad motor mixer.
`timescale 1ns / 1ps
package qmm_pkg;

  // Hold time in ms that the yaw stick must exceed to arm or disarm.
  localparam logic [31:0] HOLD_MS = 32'd5000;
  // Smallest throttle in Q1.15 that drives the motors (just above 0.01).
  localparam logic signed [15:0] DRIVE_MIN_Q15 = 16'sd328;
  // Full thrust in Q1.15.
  localparam logic [15:0] ONE_Q15 = 16'd32768;
  // Bits of the division quotient: the numerator is |diff| times 2^15.
  localparam int unsigned DIV_BITS = 28;

  // Item commands.
  localparam logic CMD_STICK = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // Receiver channels that carry stored sticks.
  localparam logic [2:0] CH_THROTTLE = 3'd2;
  localparam logic [2:0] CH_YAW      = 3'd3;

  // Arming events reported with each result.
  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_TIMING   = 2'd1;
  localparam logic [1:0] EV_ARMED    = 2'd2;
  localparam logic [1:0] EV_DISARMED = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_PWM_MIN       = 3'd0;
  localparam logic [2:0] REG_PWM_MAX       = 3'd1;
  localparam logic [2:0] REG_THRUST_MIN    = 3'd2;
  localparam logic [2:0] REG_THRUST_MAX    = 3'd3;
  localparam logic [2:0] REG_THRUST_CENTER = 3'd4;
  localparam logic [2:0] REG_ARM_HIGH      = 3'd5;
  localparam logic [2:0] REG_ARM_LOW       = 3'd6;

  typedef struct packed {
    logic               cmd;
    logic [2:0]         channel;
    logic [11:0]        pwm;
    logic signed [15:0] roll_corr;
    logic signed [15:0] pitch_corr;
    logic signed [15:0] yaw_corr;
    logic [31:0]        now_ms;
  } in_item_t;

  typedef struct packed {
    logic [11:0] motor0_pwm;
    logic [11:0] motor1_pwm;
    logic [11:0] motor2_pwm;
    logic [11:0] motor3_pwm;
    logic        armed;
    logic [1:0]  arm_event;
  } out_item_t;

  // Configuration register set.
  typedef struct packed {
    logic [11:0] pwm_min;
    logic [11:0] pwm_max;
    logic [11:0] thrust_min;
    logic [11:0] thrust_max;
    logic [11:0] thrust_center;
    logic [11:0] arm_high;
    logic [11:0] arm_low;
  } cfg_t;

  // Control step handed from the front to the back.
  typedef struct packed {
    logic signed [15:0] roll_corr;
    logic signed [15:0] pitch_corr;
    logic signed [15:0] yaw_corr;
    logic [11:0]        throttle;
    logic               armed;
    logic [1:0]         arm_event;
  } job_t;

  // Queue status seen by its two sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ----- design/qmm_front.sv -----
// Front part: stores sticks and runs the arm/disarm hold timer per control step.
`timescale 1ns / 1ps
module qmm_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  qmm_pkg::in_item_t item_i,
  input  qmm_pkg::cfg_t     cfg_i,
  output logic             job_push_o,
  output qmm_pkg::job_t     job_o
);

  logic [11:0] throttle_q, throttle_d;
  logic [11:0] yaw_q, yaw_d;
  logic        armed_q, armed_d;
  logic [31:0] hold_q, hold_d;

  logic        arm_hold, disarm_hold;
  logic        armed_1;
  logic [31:0] hold_1, elapsed_0, elapsed_1;
  logic [1:0]  ev_0, ev_1;
  logic        is_step;

  assign is_step = accept_i && (item_i.cmd == qmm_pkg::CMD_STEP);

  // Arming check, then disarming check on the updated state.
  always_comb begin
    arm_hold    = !armed_q && (yaw_q > cfg_i.arm_high);
    elapsed_0   = item_i.now_ms - hold_q;
    armed_1     = armed_q;
    hold_1      = hold_q;
    ev_0        = qmm_pkg::EV_NONE;
    if (arm_hold && (hold_q == 32'd0)) begin
      hold_1 = item_i.now_ms;
      ev_0   = qmm_pkg::EV_TIMING;
    end else if (arm_hold && (elapsed_0 > qmm_pkg::HOLD_MS)) begin
      armed_1 = 1'b1;
      hold_1  = 32'd0;
      ev_0    = qmm_pkg::EV_ARMED;
    end
    disarm_hold = armed_1 && (yaw_q < cfg_i.arm_low);
    elapsed_1   = item_i.now_ms - hold_1;
    armed_d     = armed_1;
    hold_d      = hold_1;
    ev_1        = ev_0;
    if (disarm_hold && (hold_1 == 32'd0)) begin
      hold_d = item_i.now_ms;
      ev_1   = qmm_pkg::EV_TIMING;
    end else if (disarm_hold && (elapsed_1 > qmm_pkg::HOLD_MS)) begin
      armed_d = 1'b0;
      hold_d  = 32'd0;
      ev_1    = qmm_pkg::EV_DISARMED;
    end
  end

  // Stick updates on the throttle and yaw channels.
  always_comb begin
    throttle_d = throttle_q;
    yaw_d      = yaw_q;
    if (accept_i && (item_i.cmd == qmm_pkg::CMD_STICK)) begin
      if (item_i.channel == qmm_pkg::CH_THROTTLE) begin
        throttle_d = item_i.pwm;
      end else if (item_i.channel == qmm_pkg::CH_YAW) begin
        yaw_d = item_i.pwm;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      throttle_q <= '0;
      yaw_q      <= '0;
      armed_q    <= 1'b0;
      hold_q     <= '0;
    end else begin
      throttle_q <= throttle_d;
      yaw_q      <= yaw_d;
      if (is_step) begin
        armed_q <= armed_d;
        hold_q  <= hold_d;
      end
    end
  end

  // Job for the back part: corrections, throttle stick and arming outcome.
  assign job_push_o      = is_step;
  assign job_o.roll_corr  = item_i.roll_corr;
  assign job_o.pitch_corr = item_i.pitch_corr;
  assign job_o.yaw_corr   = item_i.yaw_corr;
  assign job_o.throttle   = throttle_q;
  assign job_o.armed      = armed_d;
  assign job_o.arm_event  = ev_1;

endmodule

// ----- design/qmm_fifo.sv -----
// Two-entry job queue between the front and the back part.
`timescale 1ns / 1ps
`include "quad_motor_mixer_with_arming_top_defines.svh"
module qmm_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  qmm_pkg::job_t        data_i,
  input  logic                 pop_i,
  output qmm_pkg::job_t        data_o,
  output qmm_pkg::q_status_t   status_o
);

  logic [1:0]    count_q, count_d;
  logic          wr_ptr_q, rd_ptr_q;
  qmm_pkg::job_t mem_q [2];
  logic          do_push, do_pop;

  assign do_push = push_i && (count_q != 2'd2);
  assign do_pop  = pop_i && (count_q != 2'd0);

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == 2'd2);
  assign status_o.empty = (count_q == 2'd0);

  // The fill count never passes the depth and tracks the pointers.
  `QMM_ASSERT_NEVER(a_count_range, count_q == 2'd3, "job queue count out of range")
  `QMM_ASSERT(a_ptr_match, (count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q), "job queue pointers disagree with count")

endmodule

// ----- design/qmm_back.sv -----
// Back part: throttle normalization by a serial divider, then motor mixing.
`timescale 1ns / 1ps
`include "quad_motor_mixer_with_arming_top_defines.svh"
module qmm_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qmm_pkg::cfg_t       cfg_i,
  input  qmm_pkg::job_t       job_i,
  input  qmm_pkg::q_status_t  q_status_i,
  output logic                job_pop_o,
  output logic                out_valid_o,
  output qmm_pkg::out_item_t  out_o,
  input  logic                out_pop_i
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_SAT  = 3'd2;
  localparam logic [2:0] ST_MIX  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [4:0]  cnt_q;
  logic [2:0]  mix_q;
  qmm_pkg::job_t job_q;
  logic [qmm_pkg::DIV_BITS-1:0] num_q;
  logic [11:0] div_q;
  logic [11:0] rem_q;
  logic        neg_q, zero_q;
  logic signed [15:0] thr_q;
  logic signed [29:0] prod_q;
  logic [11:0] pwm_q [4];
  logic        out_valid_q;
  qmm_pkg::out_item_t out_q;

  logic signed [12:0] diff, span;
  logic [11:0] diff_abs, span_abs;
  logic [12:0] rem_sh;
  logic        q_bit;
  logic signed [15:0] thr_sat;
  logic [1:0]  motor;
  logic signed [16:0] corr_a, corr_y;
  logic signed [18:0] mix_sum;
  logic [15:0] thrust;
  logic signed [12:0] pwm_span;
  logic signed [29:0] prod;
  logic signed [30:0] pulse_v;
  logic [11:0] pulse;
  logic        drive;
  logic        load_out;

  // Normalization operands.
  assign diff     = $signed({1'b0, job_i.throttle}) - $signed({1'b0, cfg_i.thrust_center});
  assign span     = $signed({1'b0, cfg_i.thrust_max}) - $signed({1'b0, cfg_i.thrust_min});
  assign diff_abs = diff[12] ? 12'(-diff) : diff[11:0];
  assign span_abs = span[12] ? 12'(-span) : span[11:0];

  // One restoring division step per cycle; the quotient shifts into num_q.
  assign rem_sh = {rem_q, num_q[qmm_pkg::DIV_BITS-1]};
  assign q_bit  = (rem_sh >= {1'b0, div_q});

  // Truncated quotient with sign, saturated to Q1.15.
  always_comb begin
    if (zero_q) begin
      thr_sat = 16'sd0;
    end else if (neg_q) begin
      thr_sat = (num_q > 28'd32768) ? -16'sd32768 : 16'(-num_q);
    end else begin
      thr_sat = (num_q > 28'd32767) ? 16'sd32767 : num_q[15:0];
    end
  end

  // Thrust of the motor in work: throttle with doubled corrections added or subtracted, clamped.
  assign motor = mix_q[1:0];
  always_comb begin
    corr_a = (motor[1] == 1'b0) ? {job_q.roll_corr, 1'b0} : {job_q.pitch_corr, 1'b0};
    corr_y = {job_q.yaw_corr, 1'b0};
    mix_sum = 19'(thr_q);
    if (motor == 2'd0 || motor == 2'd3) begin
      mix_sum = mix_sum + 19'(corr_a);
    end else begin
      mix_sum = mix_sum - 19'(corr_a);
    end
    if (motor[1] == 1'b0) begin
      mix_sum = mix_sum + 19'(corr_y);
    end else begin
      mix_sum = mix_sum - 19'(corr_y);
    end
    if (mix_sum < 0) begin
      thrust = 16'd0;
    end else if (mix_sum > $signed({3'b0, qmm_pkg::ONE_Q15})) begin
      thrust = qmm_pkg::ONE_Q15;
    end else begin
      thrust = mix_sum[15:0];
    end
  end

  assign pwm_span = $signed({1'b0, cfg_i.pwm_max}) - $signed({1'b0, cfg_i.pwm_min});
  assign prod     = pwm_span * $signed({1'b0, thrust});

  // Pulse width from the registered product.
  always_comb begin
    pulse_v = $signed({4'b0, cfg_i.pwm_min, 15'b0}) + 31'(prod_q);
    if (pulse_v < 0) begin
      pulse = 12'd0;
    end else if (pulse_v[30:15] > 16'd4095) begin
      pulse = 12'd4095;
    end else begin
      pulse = pulse_v[26:15];
    end
  end

  assign drive    = job_q.armed && (thr_q >= qmm_pkg::DRIVE_MIN_Q15);
  assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_pop_i);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (!q_status_i.empty) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_q == 5'(qmm_pkg::DIV_BITS - 1)) begin
          state_d = ST_SAT;
        end
      end
      ST_SAT: state_d = ST_MIX;
      ST_MIX: begin
        if (mix_q == 3'd4) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign job_pop_o = (state_q == ST_IDLE) && !q_status_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      mix_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_IDLE) begin
        cnt_q <= '0;
        mix_q <= '0;
      end
      if (state_q == ST_DIV) begin
        cnt_q <= cnt_q + 5'd1;
      end
      if (state_q == ST_MIX) begin
        mix_q <= mix_q + 3'd1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q  <= job_i;
      num_q  <= {1'b0, diff_abs, 15'b0};
      div_q  <= span_abs;
      rem_q  <= '0;
      neg_q  <= diff[12] ^ span[12];
      zero_q <= (span == 13'sd0);
    end
    if (state_q == ST_DIV) begin
      rem_q <= q_bit ? 12'(rem_sh - {1'b0, div_q}) : rem_sh[11:0];
      num_q <= {num_q[qmm_pkg::DIV_BITS-2:0], q_bit};
    end
    if (state_q == ST_SAT) begin
      thr_q <= thr_sat;
    end
    if (state_q == ST_MIX) begin
      if (mix_q != 3'd4) begin
        prod_q <= prod;
      end
      if (mix_q != 3'd0) begin
        pwm_q[2'(mix_q - 3'd1)] <= drive ? pulse : cfg_i.pwm_min;
      end
    end
    if (load_out) begin
      out_q.motor0_pwm <= pwm_q[0];
      out_q.motor1_pwm <= pwm_q[1];
      out_q.motor2_pwm <= pwm_q[2];
      out_q.motor3_pwm <= pwm_q[3];
      out_q.armed      <= job_q.armed;
      out_q.arm_event  <= job_q.arm_event;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // A waiting result stays until taken, and a just-armed result reports armed.
  `QMM_ASSERT(a_out_held, (out_valid_q && !out_pop_i) |=> out_valid_q, "result dropped without pop")
  `QMM_ASSERT(a_armed_event, (out_valid_q && out_q.arm_event == qmm_pkg::EV_ARMED) |-> out_q.armed, "armed event without armed state")
  `QMM_ASSERT(a_div_len, (state_q == ST_SAT) |-> ($past(state_q) == ST_DIV), "saturation entered without division")

endmodule

// ----- design/quad_motor_mixer_with_arming_top.sv -----
// Top level of the quad X-frame motor mixer with stick arming.
//
// Usage: items enter through push/full. A stick update (cmd 0) stores the
// throttle or yaw stick and gives no result. A control step (cmd 1) runs
// the arming hold timer in the front part in the cycle it is accepted and
// leaves a job in a two-entry queue. The back part takes each job through
// a serial divider that normalizes the throttle, then mixes one motor per
// cycle through a shared multiplier. The back part finishes one control
// step before it takes the next job from the queue.
// Results leave through empty/pop from a one-entry output register; while
// it is not taken the back part waits with the next finished result and the
// queue fills, after which full is raised. Configuration beats on the
// cfg channel are always taken and must come while the block is idle.
// Reset clears the sticks, disarms, stops the hold timer, empties the queue
// and loads the default register values.
`timescale 1ns / 1ps
module quad_motor_mixer_with_arming_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  qmm_pkg::in_item_t   item_i,
  output logic                empty,
  input  logic                pop,
  output qmm_pkg::out_item_t  result_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [11:0]         cfg_data_i
);

  qmm_pkg::cfg_t      cfg_q;
  qmm_pkg::job_t      job_in, job_out;
  qmm_pkg::q_status_t q_status;
  logic               job_push, job_pop, out_valid, accept;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;
  assign full        = q_status.full;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pwm_min       <= 12'd1000;
      cfg_q.pwm_max       <= 12'd2000;
      cfg_q.thrust_min    <= 12'd1000;
      cfg_q.thrust_max    <= 12'd2000;
      cfg_q.thrust_center <= 12'd1000;
      cfg_q.arm_high      <= 12'd1900;
      cfg_q.arm_low       <= 12'd1100;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        qmm_pkg::REG_PWM_MIN:       cfg_q.pwm_min       <= cfg_data_i;
        qmm_pkg::REG_PWM_MAX:       cfg_q.pwm_max       <= cfg_data_i;
        qmm_pkg::REG_THRUST_MIN:    cfg_q.thrust_min    <= cfg_data_i;
        qmm_pkg::REG_THRUST_MAX:    cfg_q.thrust_max    <= cfg_data_i;
        qmm_pkg::REG_THRUST_CENTER: cfg_q.thrust_center <= cfg_data_i;
        qmm_pkg::REG_ARM_HIGH:      cfg_q.arm_high      <= cfg_data_i;
        qmm_pkg::REG_ARM_LOW:       cfg_q.arm_low       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  qmm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (item_i),
    .cfg_i      (cfg_q),
    .job_push_o (job_push),
    .job_o      (job_in)
  );

  qmm_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (job_push),
    .data_i   (job_in),
    .pop_i    (job_pop),
    .data_o   (job_out),
    .status_o (q_status)
  );

  qmm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_i       (job_out),
    .q_status_i  (q_status),
    .job_pop_o   (job_pop),
    .out_valid_o (out_valid),
    .out_o       (result_o),
    .out_pop_i   (pop)
  );

  assign empty = !out_valid;

endmodule
